/* sv/kbgc_pkg.sv */
package kbgc_pkg;

  // Width of the wrapping millisecond time held in state; the input field stays 32 bits.
  localparam int unsigned TIME_BITS = 32;

  typedef logic [TIME_BITS-1:0] time_ms_t;

  // Rotation step codes.
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_CW   = 2'd1;
  localparam logic [1:0] STEP_CCW  = 2'd2;

  // Rotation event codes.
  localparam logic [2:0] ROT_NONE      = 3'd0;
  localparam logic [2:0] ROT_UP_HELD   = 3'd1;
  localparam logic [2:0] ROT_UP        = 3'd2;
  localparam logic [2:0] ROT_DOWN_HELD = 3'd3;
  localparam logic [2:0] ROT_DOWN      = 3'd4;

  // Button event codes.
  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_SINGLE = 2'd1;
  localparam logic [1:0] BTN_DOUBLE = 2'd2;
  localparam logic [1:0] BTN_LONG   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_DBL_WIN  = 2'd1;
  localparam logic [1:0] CFG_LONG     = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] DBL_WIN_RST  = 16'd300;
  localparam logic [15:0] LONG_RST     = 16'd1000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_level;
    logic [1:0]  rotation_step;
  } kbgc_in_t;

  typedef struct packed {
    logic [2:0] rotation_event;
    logic [1:0] button_event;
    logic       activity;
  } kbgc_out_t;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] double_click_window;
    logic [15:0] long_press_time;
  } kbgc_cfg_t;

  typedef struct packed {
    logic     debounced_level;
    logic     click_pending;
    logic     rotated_since_press;
    time_ms_t last_release_time;
    time_ms_t last_press_time;
    time_ms_t last_click_time;
  } kbgc_state_t;

  function automatic time_ms_t since_ms(time_ms_t now, time_ms_t then);
    return now - then;
  endfunction

endpackage

/* sv/knob_button_gesture_classifier.sv */
// Path: a beat accepted at the input is held in the input register, then moves into the
// result register, which presents it at the output.
// Throughput: one beat per cycle; the gesture state updates as a beat moves from the input
// register into the result register, and a stalled result holds the input register.
// Reset (asynchronous, active low) empties both registers, restores the gesture
// state to released with no pending click and loads the default timings.
module knob_button_gesture_classifier import kbgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  kbgc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output kbgc_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  kbgc_in_t    in_q;
  logic        in_vld_q;
  kbgc_out_t   out_q;
  logic        out_vld_q;
  kbgc_cfg_t   cfg_q;
  kbgc_state_t state_q;
  kbgc_state_t state_d;
  kbgc_out_t   res_d;
  logic        fire;

  assign fire        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || fire;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  kbgc_step u_step (
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time       <= DEBOUNCE_RST;
      cfg_q.double_click_window <= DBL_WIN_RST;
      cfg_q.long_press_time     <= LONG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_q.debounce_time       <= cfg_data_i;
        CFG_DBL_WIN:  cfg_q.double_click_window <= cfg_data_i;
        CFG_LONG:     cfg_q.long_press_time     <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q                    <= 1'b0;
      out_vld_q                   <= 1'b0;
      state_q.debounced_level     <= 1'b1;
      state_q.click_pending       <= 1'b0;
      state_q.rotated_since_press <= 1'b0;
      state_q.last_release_time   <= '0;
      state_q.last_press_time     <= '0;
      state_q.last_click_time     <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

endmodule

/* sv/kbgc_step.sv */
module kbgc_step import kbgc_pkg::*; (
  input  kbgc_in_t    item_i,
  input  kbgc_cfg_t   cfg_i,
  input  kbgc_state_t state_i,
  output kbgc_state_t state_o,
  output kbgc_out_t   res_o
);

  time_ms_t now;
  time_ms_t since_rel;
  time_ms_t since_press;
  time_ms_t since_click;
  time_ms_t deb_t;
  time_ms_t win_t;
  time_ms_t long_t;
  logic     held;
  logic     turned;
  logic     rot_mark;

  assign now         = item_i.now_ms[TIME_BITS-1:0];
  assign since_rel   = since_ms(now, state_i.last_release_time);
  assign since_press = since_ms(now, state_i.last_press_time);
  assign since_click = since_ms(now, state_i.last_click_time);
  assign deb_t       = time_ms_t'(cfg_i.debounce_time);
  assign win_t       = time_ms_t'(cfg_i.double_click_window);
  assign long_t      = time_ms_t'(cfg_i.long_press_time);
  assign held        = ~item_i.button_level;
  assign turned      = (item_i.rotation_step == STEP_CW) || (item_i.rotation_step == STEP_CCW);
  // A turn in this very poll already counts against the pending click and the long press.
  assign rot_mark    = state_i.rotated_since_press | turned;

  always_comb begin
    state_o                     = state_i;
    state_o.rotated_since_press = rot_mark;
    res_o.rotation_event        = ROT_NONE;
    res_o.button_event          = BTN_NONE;
    res_o.activity              = turned;

    case (item_i.rotation_step)
      STEP_CW:  res_o.rotation_event = held ? ROT_UP_HELD : ROT_UP;
      STEP_CCW: res_o.rotation_event = held ? ROT_DOWN_HELD : ROT_DOWN;
      default:  res_o.rotation_event = ROT_NONE;
    endcase

    if (state_i.click_pending && !rot_mark && (since_click >= win_t)) begin
      state_o.click_pending = 1'b0;
      res_o.button_event    = BTN_SINGLE;
      res_o.activity        = 1'b1;
    end

    if (held && state_i.debounced_level) begin
      if (since_rel > deb_t) begin
        state_o.click_pending       = 1'b0;
        state_o.debounced_level     = 1'b0;
        state_o.last_press_time     = now;
        state_o.rotated_since_press = 1'b0;
        res_o.activity              = 1'b1;
      end
    end else if (!held && !state_i.debounced_level) begin
      if (since_press >= deb_t) begin
        state_o.last_release_time = now;
        state_o.debounced_level   = 1'b1;
        if ((since_press > long_t) && !rot_mark) begin
          res_o.button_event = BTN_LONG;
        end else if (since_click < win_t) begin
          res_o.button_event    = BTN_DOUBLE;
          res_o.activity        = 1'b1;
          state_o.click_pending = 1'b0;
        end else begin
          state_o.click_pending   = 1'b1;
          state_o.last_click_time = now;
          res_o.activity          = 1'b1;
        end
      end
    end
  end

endmodule

/* verif/knob_button_gesture_classifier_tb.sv */
module knob_button_gesture_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kbgc_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  kbgc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kbgc_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_DEBOUNCE;
  logic [15:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  knob_button_gesture_classifier DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_data_i    (in_data),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_o   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  // Gesture tracker state and timings, mirrored from the block's point of view.
  logic [15:0] deb_gap_ms  = DEBOUNCE_RST;
  logic [15:0] dbl_win_ms  = DBL_WIN_RST;
  logic [15:0] long_ms     = LONG_RST;
  logic        btn_level = 1'b1;
  logic        click_waiting = 1'b0;
  logic        knob_turned = 1'b0;
  time_ms_t    release_at = '0;
  time_ms_t    press_at = '0;
  time_ms_t    click_at = '0;

  kbgc_out_t   gesture_q[$];
  int unsigned polls_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned singles = 0;
  int unsigned doubles = 0;
  int unsigned longs = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] poll_ms = '0;
  logic        poll_level = 1'b1;

  function automatic kbgc_out_t classify_poll(kbgc_in_t p);
    time_ms_t  now;
    time_ms_t  d_release;
    time_ms_t  d_press;
    time_ms_t  d_click;
    logic      held;
    kbgc_out_t r;
    now = p.now_ms[TIME_BITS-1:0];
    // None of the three reference times move before they are last read.
    d_release = now - release_at;
    d_press = now - press_at;
    d_click = now - click_at;
    held = !p.button_level;
    r = '0;
    if (p.rotation_step == STEP_CW) begin
      r.rotation_event = held ? ROT_UP_HELD : ROT_UP;
      knob_turned = 1'b1;
      r.activity = 1'b1;
    end else if (p.rotation_step == STEP_CCW) begin
      r.rotation_event = held ? ROT_DOWN_HELD : ROT_DOWN;
      knob_turned = 1'b1;
      r.activity = 1'b1;
    end
    if (click_waiting && !knob_turned && d_click >= dbl_win_ms) begin
      click_waiting = 1'b0;
      r.button_event = BTN_SINGLE;
      r.activity = 1'b1;
      singles++;
    end
    if (!p.button_level && btn_level) begin
      if (d_release > deb_gap_ms) begin
        click_waiting = 1'b0;
        r.activity = 1'b1;
        btn_level = 1'b0;
        press_at = now;
        knob_turned = 1'b0;
      end
    end else if (p.button_level && !btn_level) begin
      if (d_press >= deb_gap_ms) begin
        release_at = now;
        btn_level = 1'b1;
        if (d_press > long_ms && !knob_turned) begin
          r.button_event = BTN_LONG;
          longs++;
        end else if (d_click < dbl_win_ms) begin
          r.button_event = BTN_DOUBLE;
          r.activity = 1'b1;
          click_waiting = 1'b0;
          doubles++;
        end else begin
          click_waiting = 1'b1;
          r.activity = 1'b1;
          click_at = now;
        end
      end
    end
    return r;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    kbgc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (gesture_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: rot %0d btn %0d act %0d",
                   out_data.rotation_event, out_data.button_event, out_data.activity);
      end else begin
        want = gesture_q.pop_front();
        if (out_data.rotation_event !== want.rotation_event ||
            out_data.button_event !== want.button_event ||
            out_data.activity !== want.activity) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected rot %0d btn %0d act %0d, got rot %0d btn %0d act %0d",
                     results_seen, want.rotation_event, want.button_event, want.activity,
                     out_data.rotation_event, out_data.button_event, out_data.activity);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timed out with %0d results outstanding", gesture_q.size());
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_poll(input logic [31:0] now, input logic lvl, input logic [1:0] stp);
    kbgc_in_t p;
    p = {now, lvl, stp};
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    gesture_q.push_back(classify_poll(p));
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (gesture_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_timings(input logic [15:0] db, input logic [15:0] win,
                             input logic [15:0] lng);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_DEBOUNCE;
    cfg_data <= db;
    @(negedge clk);
    cfg_idx <= CFG_DBL_WIN;
    cfg_data <= win;
    @(negedge clk);
    cfg_idx <= CFG_LONG;
    cfg_data <= lng;
    @(negedge clk);
    cfg_we <= 1'b0;
    deb_gap_ms = db;
    dbl_win_ms = win;
    long_ms = lng;
  endtask

  // A gap that lands on, just either side of, or somewhere around a threshold.
  function automatic logic [31:0] near(input logic [15:0] thr);
    case ($urandom_range(0, 3))
      0: return (thr == 0) ? 32'd0 : 32'(thr) - 1;
      1: return 32'(thr);
      2: return 32'(thr) + 1;
      default: return $urandom_range(0, 2 * thr + 2);
    endcase
  endfunction

  // Mostly plausible press/hold/release sequences, with some bounce and noise.
  task automatic run_polls(input int unsigned n);
    logic [1:0] stp;
    for (int unsigned i = 0; i < n; i++) begin
      stp = ($urandom_range(0, 99) < 80) ? STEP_NONE : 2'($urandom_range(1, 3));
      if ($urandom_range(0, 99) < 8) begin
        poll_level = 1'($urandom_range(0, 1));
        stp = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
          poll_ms = $urandom;
        else
          poll_ms += $urandom_range(0, 40);
      end else if ($urandom_range(0, 99) < 40) begin
        poll_level = !poll_level;
        if (!poll_level)
          poll_ms += near(deb_gap_ms);
        else
          poll_ms += ($urandom_range(0, 2) == 0) ? near(long_ms) : near(deb_gap_ms);
      end else begin
        poll_ms += $urandom_range(0, 1) ? near(dbl_win_ms) : $urandom_range(0, 20);
      end
      send_poll(poll_ms, poll_level, stp);
    end
  endtask

  task automatic test_directed_cases();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_poll(32'd0, 1'b1, STEP_NONE);
    send_poll(32'd10, 1'b0, STEP_CW);       // press too soon after the reset release
    send_poll(32'd51, 1'b0, STEP_CCW);      // press just past the debounce time
    send_poll(32'd60, 1'b1, 2'd3);          // unused step code, release bounces
    send_poll(32'd101, 1'b1, STEP_NONE);    // release close to time zero: double click
    send_poll(32'd200, 1'b0, STEP_NONE);
    send_poll(32'd1300, 1'b1, STEP_NONE);   // long press
    send_poll(32'd1400, 1'b0, STEP_NONE);
    send_poll(32'd1500, 1'b1, STEP_CW);     // turned on the release poll: click is never delivered
    send_poll(32'd1900, 1'b1, STEP_NONE);
    send_poll(32'd2000, 1'b0, STEP_NONE);
    send_poll(32'd2100, 1'b1, STEP_NONE);
    send_poll(32'd2200, 1'b0, STEP_NONE);
    send_poll(32'd2300, 1'b1, STEP_NONE);   // double click
    send_poll(32'd2400, 1'b0, STEP_NONE);
    send_poll(32'd2500, 1'b1, STEP_NONE);
    send_poll(32'd2800, 1'b1, STEP_NONE);   // window expires exactly: single click
    send_poll(32'd2810, 1'b1, STEP_CCW);
    send_poll(32'd2820, 1'b1, STEP_CW);
    send_poll(32'hFFFF_FF00, 1'b0, STEP_NONE);
    send_poll(32'hFFFF_FFFF, 1'b0, STEP_CCW);
    send_poll(32'h0000_0100, 1'b1, STEP_NONE); // release across the wrap
    send_poll(32'h0000_0400, 1'b1, STEP_NONE);
    poll_ms = 32'h0000_0400;
    poll_level = 1'b1;
  endtask

  task automatic test_zero_timings();
    set_timings(16'd0, 16'd0, 16'd0);
    tx_idle_pct = 83;
    rx_stall_pct = 0;
    run_polls(250);
  endtask

  task automatic test_max_timings();
    set_timings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    tx_idle_pct = 0;
    rx_stall_pct = 83;
    run_polls(250);
  endtask

  task automatic test_random_timings();
    for (int k = 0; k < 3; k++) begin
      set_timings(16'($urandom_range(0, 100)), 16'($urandom_range(0, 600)),
                  16'($urandom_range(0, 2000)));
      tx_idle_pct = 29;
      rx_stall_pct = 29;
      run_polls(100);
    end
  endtask

  task automatic test_default_timings();
    set_timings(DEBOUNCE_RST, DBL_WIN_RST, LONG_RST);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_polls(300);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    run_polls(250);
    test_zero_timings();
    test_max_timings();
    test_random_timings();
    test_default_timings();
    settle();
    repeat (6) @(negedge clk);
    $display("Checked %0d results from %0d polls across seven timing settings.",
             results_seen, polls_sent);
    $display("Gestures seen: %0d single, %0d double, %0d long; %0d mismatches.",
             singles, doubles, longs, mismatches);
    if (mismatches == 0 && gesture_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
